FILE: rtl/bev_pkg.sv
// ----------------------------------------------------------------------------
// bev_pkg: shared types and constants of the button event qualifier
// Register indexes, reset values, field widths and the config/event structs.
// ----------------------------------------------------------------------------
package bev_pkg;

	localparam int TIME_BITS_DEF = 32;
	localparam int NOW_W         = 32;
	localparam int THR_W         = 16;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;
	localparam int CLICK_W       = 2;
	localparam int IN_TDATA_W    = 40;
	localparam int OUT_TDATA_W   = 8;

	// register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PULL_UP     = 3'd0,
		REG_BOUNCE      = 3'd1,
		REG_DOUBLECLICK = 3'd2,
		REG_INACTIVITY  = 3'd3,
		REG_HOLD        = 3'd4
	} reg_idx_t;

	localparam logic             PULL_UP_RST     = 1'b1;
	localparam logic [THR_W-1:0] BOUNCE_RST      = 16'd50;
	localparam logic [THR_W-1:0] DOUBLECLICK_RST = 16'd300;
	localparam logic [THR_W-1:0] INACTIVITY_RST  = 16'd5000;
	localparam logic [THR_W-1:0] HOLD_RST        = 16'd1000;

	// second settled press inside the window
	localparam logic [CLICK_W-1:0] DOUBLE_COUNT = 2'd2;

	typedef struct packed {
		logic             pull_up;
		logic [THR_W-1:0] bounce_ms;
		logic [THR_W-1:0] doubleclick_ms;
		logic [THR_W-1:0] inactivity_ms;
		logic [THR_W-1:0] hold_ms;
	} cfg_t;

	// lowest bit first: press, release, double, idle, hold
	typedef struct packed {
		logic hold_pulse;
		logic idle_pulse;
		logic double_pulse;
		logic release_pulse;
		logic press_pulse;
	} evt_t;

endpackage

FILE: rtl/bev_cfg_regs.sv
// ----------------------------------------------------------------------------
// bev_cfg_regs: configuration register file
// Write-only registers; indexes outside the map are dropped.
// ----------------------------------------------------------------------------
module bev_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bev_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bev_pkg::CFG_DATA_W-1:0]   cfg_data,
	output bev_pkg::cfg_t                    cfg
);

	bev_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pull_up        <= bev_pkg::PULL_UP_RST;
			cfg_q.bounce_ms      <= bev_pkg::BOUNCE_RST;
			cfg_q.doubleclick_ms <= bev_pkg::DOUBLECLICK_RST;
			cfg_q.inactivity_ms  <= bev_pkg::INACTIVITY_RST;
			cfg_q.hold_ms        <= bev_pkg::HOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bev_pkg::REG_PULL_UP:     cfg_q.pull_up        <= cfg_data[0];
				bev_pkg::REG_BOUNCE:      cfg_q.bounce_ms      <= cfg_data;
				bev_pkg::REG_DOUBLECLICK: cfg_q.doubleclick_ms <= cfg_data;
				bev_pkg::REG_INACTIVITY:  cfg_q.inactivity_ms  <= cfg_data;
				bev_pkg::REG_HOLD:        cfg_q.hold_ms        <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/bev_eval.sv
// ----------------------------------------------------------------------------
// bev_eval: per-poll evaluation and button state
// Elapsed time, threshold edges, click counter; state advances on step.
// ----------------------------------------------------------------------------
module bev_eval #(
	parameter int TIME_BITS = bev_pkg::TIME_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [bev_pkg::NOW_W-1:0]    now_ms,
	input  logic                         pin_level,
	input  bev_pkg::cfg_t                cfg,
	output bev_pkg::evt_t                evt
);

	localparam int WideW = (TIME_BITS > bev_pkg::NOW_W) ? TIME_BITS : bev_pkg::NOW_W;

	logic                          last_level_q;
	logic [TIME_BITS-1:0]          change_time_q;
	logic                          ever_changed_q;
	logic [bev_pkg::CLICK_W-1:0]   click_q;
	logic                          b_prev_q, d_prev_q, i_prev_q, h_prev_q;

	logic [WideW-1:0]              now_wide;
	logic [TIME_BITS-1:0]          now_t;
	logic [TIME_BITS-1:0]          elapsed;
	logic                          changed, pressed, ever_nx;
	logic                          b_over, d_over, i_over, h_over;
	logic                          b_rise, i_rise, h_rise;
	logic [bev_pkg::CLICK_W-1:0]   click_mid, click_inc, click_nx;

	assign now_wide = WideW'(now_ms);
	assign now_t    = now_wide[TIME_BITS-1:0];
	assign elapsed  = now_t - change_time_q;   // wraps mod 2^TIME_BITS
	assign changed  = (pin_level != last_level_q);
	assign ever_nx  = ever_changed_q | changed;
	assign pressed  = cfg.pull_up ? !pin_level : pin_level;

	assign b_over = elapsed > TIME_BITS'(cfg.bounce_ms);
	assign d_over = elapsed > TIME_BITS'(cfg.doubleclick_ms);
	assign i_over = elapsed > TIME_BITS'(cfg.inactivity_ms);
	assign h_over = elapsed > TIME_BITS'(cfg.hold_ms);

	assign b_rise = b_over & !b_prev_q;
	assign i_rise = i_over & !i_prev_q;
	assign h_rise = h_over & !h_prev_q;

	// window expiry clears the count before this poll's press is counted
	assign click_mid = (d_over & !d_prev_q) ? '0 : click_q;
	assign click_inc = click_mid + 1'b1;

	always_comb begin
		evt      = '0;
		click_nx = click_mid;
		if (b_rise && pressed) begin
			evt.press_pulse = 1'b1;
			if (click_inc == bev_pkg::DOUBLE_COUNT) begin
				evt.double_pulse = 1'b1;
				click_nx         = '0;
			end else begin
				click_nx = click_inc;
			end
		end
		evt.release_pulse = b_rise & !pressed & ever_nx;
		evt.idle_pulse    = i_rise & !pressed & ever_nx;
		evt.hold_pulse    = h_rise &  pressed & ever_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q   <= bev_pkg::PULL_UP_RST;
			change_time_q  <= '0;
			ever_changed_q <= 1'b0;
			click_q        <= '0;
			b_prev_q       <= 1'b0;
			d_prev_q       <= 1'b0;
			i_prev_q       <= 1'b0;
			h_prev_q       <= 1'b0;
		end else if (step) begin
			if (changed) begin
				last_level_q  <= pin_level;
				change_time_q <= now_t;
			end
			ever_changed_q <= ever_nx;
			click_q        <= click_nx;
			b_prev_q       <= b_over;
			d_prev_q       <= d_over;
			i_prev_q       <= i_over;
			h_prev_q       <= h_over;
		end
	end

endmodule

FILE: rtl/button_event_qualifier.sv
// ----------------------------------------------------------------------------
// button_event_qualifier: debounced button click / double / idle / hold events
//
// Usage: each request on the slave stream is one poll of the button pin,
// carrying the millisecond time and the raw pin level. Every poll yields
// exactly one request on the master stream with five one-poll event flags.
// An accepted poll sits in the input register and the evaluation logic feeds the
// output register that drives m_tvalid. Throughput is one poll per clock while
// m_tready stays high; the limit is the update of the button state (change time,
// edge flags, click count) between polls.
// The input register accepts while it is empty or while the output register
// advances in the same cycle, so one poll can wait behind a stalled result.
// When the receiver stalls (m_tready low) the output holds, the input
// register fills and then s_tready drops; no poll is lost or evaluated twice.
// Reset (arst_n low) empties both registers, loads the register defaults
// (pull-up on, 50/300/5000/1000 ms) and sets the stored level to idle, change
// time to zero. Configuration writes are expected only while idle and take
// effect from the next evaluated poll.
// ----------------------------------------------------------------------------
module button_event_qualifier #(
	parameter int TIME_BITS = bev_pkg::TIME_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [bev_pkg::IN_TDATA_W-1:0]    s_tdata,   // [31:0] now_ms, [32] pin_level
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [bev_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [0] press_pulse, [1] release_pulse,
	                                                     // [2] double_pulse, [3] idle_pulse,
	                                                     // [4] hold_pulse
	input  logic                              cfg_we,
	input  logic [bev_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bev_pkg::CFG_DATA_W-1:0]    cfg_data
);

	bev_pkg::cfg_t                cfg;
	bev_pkg::evt_t                evt;
	bev_pkg::evt_t                evt_s2;

	logic                         valid_s1;
	logic [bev_pkg::NOW_W-1:0]    now_s1;
	logic                         level_s1;
	logic                         advance;   // output register free this cycle
	logic                         step;      // poll evaluated this cycle

	assign advance  = !m_tvalid || m_tready;
	assign step     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	bev_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bev_eval #(
		.TIME_BITS (TIME_BITS)
	) u_eval (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.now_ms    (now_s1),
		.pin_level (level_s1),
		.cfg       (cfg),
		.evt       (evt)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			now_s1   <= s_tdata[bev_pkg::NOW_W-1:0];
			level_s1 <= s_tdata[bev_pkg::NOW_W];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			evt_s2 <= evt;
		end
	end

	assign m_tdata = bev_pkg::OUT_TDATA_W'(evt_s2);

`ifndef SYNTH
	// a double click is always reported together with its press
	a_double_has_press: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!evt_s2.double_pulse || evt_s2.press_pulse))
		else $error("double pulse without press pulse");

	// press and release come from one bounce edge with opposite polarity
	a_press_release_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(evt_s2.press_pulse && evt_s2.release_pulse))
		else $error("press and release in one poll");

	// idle needs released, hold needs pressed
	a_idle_hold_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(evt_s2.idle_pulse && evt_s2.hold_pulse))
		else $error("idle and hold in one poll");

	// a poll waiting in the input register is kept until evaluated
	a_s1_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(now_s1) && $stable(level_s1)))
		else $error("stalled poll lost or changed");
`endif

endmodule

FILE: tb/bev_event_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bev_event_monitor: event prediction and result check for the qualifier
// Follows register writes and accepted polls, predicts the five event flags of
// each poll in order and compares them against every accepted result.
// ----------------------------------------------------------------------------
module bev_event_monitor
	import bev_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     mismatch_count,
	output int                     events_due
);

	cfg_t               knob;
	logic               lvl_q;
	logic [NOW_W-1:0]   chg_ms;
	logic               touched;
	logic [CLICK_W-1:0] clicks;
	logic               bounce_up;
	logic               double_up;
	logic               idle_up;
	logic               hold_up;
	evt_t               due_q[$];
	evt_t               want;
	evt_t               got;
	int                 bad;

	// one poll through the button state; returns the flags it raises
	function automatic evt_t next_events(input logic [NOW_W-1:0] now, input logic lvl);
		logic [NOW_W-1:0] span;
		logic             pressed;
		logic             b_over;
		logic             d_over;
		logic             i_over;
		logic             h_over;
		evt_t             ev;
		ev      = '0;
		span    = now - chg_ms;     // measured from the change time held so far
		pressed = knob.pull_up ? !lvl : lvl;
		if (lvl != lvl_q) begin
			touched = 1'b1;
			lvl_q   = lvl;
			chg_ms  = now;
		end
		b_over = span > NOW_W'(knob.bounce_ms);
		d_over = span > NOW_W'(knob.doubleclick_ms);
		i_over = span > NOW_W'(knob.inactivity_ms);
		h_over = span > NOW_W'(knob.hold_ms);
		// window expiry clears the count ahead of this poll's press
		if (d_over != double_up) begin
			double_up = d_over;
			if (d_over)
				clicks = '0;
		end
		if (b_over != bounce_up) begin
			bounce_up = b_over;
			if (pressed && b_over) begin
				ev.press_pulse = 1'b1;
				clicks = clicks + 1'b1;
				if (clicks == DOUBLE_COUNT) begin
					clicks          = '0;
					ev.double_pulse = 1'b1;
				end
			end
			ev.release_pulse = !pressed && b_over && touched;
		end
		if (i_over != idle_up) begin
			idle_up       = i_over;
			ev.idle_pulse = !pressed && i_over && touched;
		end
		if (h_over != hold_up) begin
			hold_up       = h_over;
			ev.hold_pulse = pressed && h_over && touched;
		end
		return ev;
	endfunction

	task automatic judge_flag(input string name, input logic exp_bit, input logic act_bit);
		if (act_bit !== exp_bit) begin
			$display("%0t: %s mismatch, expected %b, actual %b", $time, name, exp_bit, act_bit);
			bad++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			knob = '{pull_up: PULL_UP_RST, bounce_ms: BOUNCE_RST,
				doubleclick_ms: DOUBLECLICK_RST, inactivity_ms: INACTIVITY_RST,
				hold_ms: HOLD_RST};
			lvl_q     = PULL_UP_RST;
			chg_ms    = '0;
			touched   = 1'b0;
			clicks    = '0;
			bounce_up = 1'b0;
			double_up = 1'b0;
			idle_up   = 1'b0;
			hold_up   = 1'b0;
			bad       = 0;
			due_q.delete();
			mismatch_count <= 0;
			events_due     <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PULL_UP:     knob.pull_up        = cfg_data[0];
					REG_BOUNCE:      knob.bounce_ms      = cfg_data[THR_W-1:0];
					REG_DOUBLECLICK: knob.doubleclick_ms = cfg_data[THR_W-1:0];
					REG_INACTIVITY:  knob.inactivity_ms  = cfg_data[THR_W-1:0];
					REG_HOLD:        knob.hold_ms        = cfg_data[THR_W-1:0];
					default: ;
				endcase
			end
			// retire first so a result can never match a poll taken at this edge
			if (m_tvalid && m_tready) begin
				got = evt_t'(m_tdata[$bits(evt_t)-1:0]);
				if (due_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %b", $time, got);
					bad++;
				end else begin
					want = due_q.pop_front();
					judge_flag("press_pulse", want.press_pulse, got.press_pulse);
					judge_flag("release_pulse", want.release_pulse, got.release_pulse);
					judge_flag("double_pulse", want.double_pulse, got.double_pulse);
					judge_flag("idle_pulse", want.idle_pulse, got.idle_pulse);
					judge_flag("hold_pulse", want.hold_pulse, got.hold_pulse);
				end
			end
			if (s_tvalid && s_tready)
				due_q.push_back(next_events(s_tdata[NOW_W-1:0], s_tdata[NOW_W]));
			mismatch_count <= bad;
			events_due     <= due_q.size();
		end
	end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for button_event_qualifier
// Drives button polls (bounce chatter, clicks, holds, idle stretches, noise and
// time wrap) under several register settings and handshake pressures; the
// event monitor beside the block predicts and checks every result.
// ----------------------------------------------------------------------------
module tb;
	import bev_pkg::*;

	localparam int PHASE_POLLS    = 100;   // random polls per register setting
	localparam int PHASES         = 8;
	localparam int SQUEEZE_CYCLES = 60;    // long receiver hold-off
	localparam int DRAIN_CYCLES   = 6;     // settling pause after every result is in
	localparam int QUIET_LIMIT    = 2000;  // cycles without any accepted request

	// hand-picked opening polls, {pin_level, now_ms}, reset register values
	localparam logic [NOW_W:0] OPENING [23] = '{
		{1'b1, 32'd0},            // idle level, nothing elapsed
		{1'b1, 32'hFFFF_FFFF},    // every threshold crossed before any use: silent
		{1'b0, 32'd0},            // time wraps, first change: bits fall silently
		{1'b0, 32'd50},           // exactly at the settle time
		{1'b0, 32'd51},           // settled press
		{1'b1, 32'd60},           // release edge
		{1'b1, 32'd61},
		{1'b1, 32'd112},          // settled release
		{1'b0, 32'd150},
		{1'b0, 32'd151},
		{1'b0, 32'd201},          // second press inside the window: double
		{1'b0, 32'd1151},         // held past the hold time
		{1'b1, 32'd1200},
		{1'b1, 32'd1201},
		{1'b1, 32'd6201},         // release and inactivity on one poll
		{1'b0, 32'd6300},
		{1'b0, 32'd6301},
		{1'b0, 32'd6352},         // first click
		{1'b1, 32'd6360},
		{1'b1, 32'd6361},
		{1'b0, 32'd6420},         // change poll itself sees the old change time
		{1'b0, 32'd6421},
		{1'b0, 32'd6800}          // window expiry and settle on one poll
	};

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;     // [31:0] now_ms, [32] pin_level
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;     // [0] press, [1] release, [2] double,
	                                     // [3] idle, [4] hold
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	int                     mismatch_count;
	int                     events_due;

	// stimulus-side view of the registers and the poll clock
	cfg_t                   stim_cfg;
	logic [NOW_W-1:0]       ms_now;
	int unsigned            polls_sent;
	int unsigned            send_idle_pct;
	int unsigned            stall_pct;
	bit                     squeeze;
	int                     quiet_cycles;

	button_event_qualifier dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	bev_event_monitor ev_mon (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.events_due     (events_due)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Offer one poll at absolute time t; returns at the edge that takes it.
	// valid stays high into the next poll unless a sender gap is drawn.
	task automatic offer_poll(input logic [NOW_W-1:0] t, input logic lvl);
		ms_now = t;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_TDATA_W - NOW_W - 1){1'b0}}, lvl, t};
		do @(posedge clk); while (!s_tready);
		polls_sent++;
	endtask

	task automatic advance_poll(input int unsigned dt, input logic lvl);
		offer_poll(ms_now + NOW_W'(dt), lvl);
	endtask

	// contact bounce: a few polls of random level, almost no time between
	task automatic chatter();
		int unsigned flips;
		flips = $urandom_range(0, 4);
		for (int k = 0; k < flips; k++)
			advance_poll($urandom_range(0, 2), 1'($urandom_range(1)));
	endtask

	// length of a stable stretch, mostly right around one of the thresholds
	function automatic int unsigned pick_span();
		int unsigned mark;
		case ($urandom_range(5))
			0:       mark = stim_cfg.bounce_ms;
			1:       mark = stim_cfg.doubleclick_ms;
			2:       mark = stim_cfg.hold_ms;
			3:       mark = stim_cfg.inactivity_ms;
			4:       return $urandom_range(0, 3);
			default: return $urandom_range(0, 2 * stim_cfg.inactivity_ms + 10);
		endcase
		return (mark < 2) ? $urandom_range(0, mark + 2) : mark - 2 + $urandom_range(0, 4);
	endfunction

	// change to lvl, then keep it for span ms, landing on the end exactly
	task automatic settle(input logic lvl, input int unsigned span);
		int unsigned held;
		int unsigned step;
		held = 0;
		advance_poll($urandom_range(1, 3), lvl);
		while (held < span) begin
			step = $urandom_range(1, span / 3 + 1);
			if (step > span - held)
				step = span - held;
			held += step;
			advance_poll(step, lvl);
		end
		if ($urandom_range(1))
			advance_poll(1, lvl);
	endtask

	task automatic click_cycle();
		logic down;
		down = !stim_cfg.pull_up;
		chatter();
		settle(down, pick_span());
		chatter();
		settle(!down, pick_span());
	endtask

	// wait until every poll has its result, plus a short settling pause
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (events_due != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// All five registers back to back, pull_up with junk above its bit, then a
	// write to an unmapped index which must change nothing.
	task automatic apply_settings(input cfg_t c);
		cfg_we    <= 1'b1;
		cfg_index <= REG_PULL_UP;
		cfg_data  <= {(CFG_DATA_W - 1)'($urandom), c.pull_up};
		@(posedge clk);
		cfg_index <= REG_BOUNCE;
		cfg_data  <= c.bounce_ms;
		@(posedge clk);
		cfg_index <= REG_DOUBLECLICK;
		cfg_data  <= c.doubleclick_ms;
		@(posedge clk);
		cfg_index <= REG_INACTIVITY;
		cfg_data  <= c.inactivity_ms;
		@(posedge clk);
		cfg_index <= REG_HOLD;
		cfg_data  <= c.hold_ms;
		@(posedge clk);
		cfg_index <= CFG_IDX_W'(int'(REG_HOLD) + $urandom_range(1, 3));
		cfg_data  <= CFG_DATA_W'($urandom);
		@(posedge clk);
		cfg_we   <= 1'b0;
		stim_cfg  = c;
	endtask

	// receiver: random stalls per phase, one long hold-off when squeeze is set
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (squeeze) begin
				m_tready <= 1'b0;
				repeat (SQUEEZE_CYCLES - 1) @(posedge clk);
				squeeze = 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// watchdog: too long without any request moving means a hang
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("button_event_qualifier verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int unsigned phase_start;
		int unsigned tie_ms;
		cfg_t        plan;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		send_idle_pct = 0;
		stall_pct     = 0;
		squeeze       = 1'b0;
		ms_now        = '0;
		polls_sent    = 0;
		stim_cfg      = '{pull_up: PULL_UP_RST, bounce_ms: BOUNCE_RST,
			doubleclick_ms: DOUBLECLICK_RST, inactivity_ms: INACTIVITY_RST,
			hold_ms: HOLD_RST};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening on the reset register values
		foreach (OPENING[i])
			offer_poll(OPENING[i][NOW_W-1:0], OPENING[i][NOW_W]);

		for (int p = 0; p < PHASES; p++) begin
			drain();
			tie_ms = $urandom_range(1, 500);
			case (p)
				1: plan = '{pull_up: 1'b0, bounce_ms: '0, doubleclick_ms: '0,
					inactivity_ms: '0, hold_ms: '0};
				2: plan = '{pull_up: 1'b1, bounce_ms: '1, doubleclick_ms: '1,
					inactivity_ms: '1, hold_ms: '1};
				3, 5: plan = '{pull_up: 1'b0,
					bounce_ms: THR_W'($urandom_range(0, 40)),
					doubleclick_ms: THR_W'($urandom_range(20, 400)),
					inactivity_ms: THR_W'($urandom_range(100, 3000)),
					hold_ms: THR_W'($urandom_range(100, 1500))};
				4: plan = '{pull_up: 1'b1, bounce_ms: THR_W'($urandom),
					doubleclick_ms: THR_W'($urandom), inactivity_ms: THR_W'($urandom),
					hold_ms: THR_W'($urandom)};
				// all thresholds equal: every over bit moves on the same poll
				6: plan = '{pull_up: 1'b1, bounce_ms: THR_W'(tie_ms),
					doubleclick_ms: THR_W'(tie_ms), inactivity_ms: THR_W'(tie_ms),
					hold_ms: THR_W'(tie_ms)};
				7: plan = '{pull_up: 1'b0, bounce_ms: BOUNCE_RST,
					doubleclick_ms: DOUBLECLICK_RST, inactivity_ms: INACTIVITY_RST,
					hold_ms: HOLD_RST};
				default: plan = '{pull_up: PULL_UP_RST, bounce_ms: BOUNCE_RST,
					doubleclick_ms: DOUBLECLICK_RST, inactivity_ms: INACTIVITY_RST,
					hold_ms: HOLD_RST};
			endcase
			apply_settings(plan);

			// handshake pressure for this phase
			case (p % 4)
				1:       begin send_idle_pct = 79; stall_pct = 0;  end
				2:       begin send_idle_pct = 0;  stall_pct = 79; end
				3:       begin send_idle_pct = 34; stall_pct = 34; end
				default: begin send_idle_pct = 0;  stall_pct = 0;  end
			endcase
			// receiver holds off while polls keep coming: input side must back up
			if (p == 2 || p == 4)
				squeeze = 1'b1;

			// jump the poll clock so the upper time bits move and wrap
			ms_now += NOW_W'($urandom);
			phase_start = polls_sent;
			while (polls_sent - phase_start < PHASE_POLLS) begin
				if ($urandom_range(9) < 8)
					click_cycle();
				else
					advance_poll(($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 200),
						1'($urandom_range(1)));
			end
		end

		drain();
		if (mismatch_count == 0)
			$display("button_event_qualifier verification clean");
		else
			$display("button_event_qualifier verification failed");
		$finish;
	end

endmodule
